// ===== hw/rtl/tui_pkg.sv =====
// ----------------------------------------------------------------------------
// tui_pkg
// Shared types and constants of the trajectory upsample interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tui_pkg;

  localparam int unsigned SampleWidth = 32;
  localparam int unsigned CfgIndexWidth = 2;

  typedef logic signed [SampleWidth-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } in_item_t;

  typedef struct packed {
    sample_t value;
    logic    interpolated;
    logic    final_res;
  } out_item_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgStartValue   = 2'd0,
    CfgGoalValue    = 2'd1,
    CfgVelocityMode = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SlotMidBefore = 3'd0,
    SlotPrev      = 3'd1,
    SlotMidAfter  = 3'd2,
    SlotSample    = 3'd3,
    SlotMidGoal   = 3'd4
  } slot_e;

  typedef struct packed {
    sample_t x;
    sample_t p1;
    sample_t p2;
    sample_t p3;
    logic    has_prev;
    logic    last;
  } cmd_t;

  typedef struct packed {
    sample_t a;
    sample_t b;
    sample_t c;
    sample_t d;
    logic    pass;
    logic    velocity;
    logic    interpolated;
    logic    final_res;
  } mid_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tui_fifo.sv =====
// ----------------------------------------------------------------------------
// tui_fifo
// Small register queue with full and empty flags and a head read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tui_fifo #(
  parameter type T = logic,
  parameter int unsigned Depth = 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tui_front.sv =====
// ----------------------------------------------------------------------------
// tui_front
// Accepts samples, keeps the three-sample window and forms one command per
// sample that produces results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tui_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  logic               accept_i,
  input  tui_pkg::in_item_t  item_i,
  input  tui_pkg::sample_t   start_i,
  output logic               cmd_push_o,
  output tui_pkg::cmd_t      cmd_o
);

  tui_pkg::sample_t oldest_q, middle_q, newest_q;
  logic [1:0]       seen_q;

  always_comb begin
    cmd_o.x        = item_i.sample;
    cmd_o.p1       = (seen_q >= 2'd1) ? newest_q : start_i;
    cmd_o.p2       = (seen_q >= 2'd2) ? middle_q : start_i;
    cmd_o.p3       = (seen_q == 2'd3) ? oldest_q : start_i;
    cmd_o.has_prev = (seen_q != 2'd0);
    cmd_o.last     = item_i.last;
  end

  assign cmd_push_o = accept_i && (cmd_o.has_prev || cmd_o.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      middle_q <= '0;
      newest_q <= '0;
      seen_q   <= '0;
    end else if (accept_i) begin
      if (item_i.last) begin
        oldest_q <= '0;
        middle_q <= '0;
        newest_q <= '0;
        seen_q   <= '0;
      end else begin
        oldest_q <= middle_q;
        middle_q <= newest_q;
        newest_q <= item_i.sample;
        if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tui_midpoint.sv =====
// ----------------------------------------------------------------------------
// tui_midpoint
// Five-stage pipeline that forms one result per cycle: a passed sample, the
// rounded two-point mean, or the rounded and saturated four-point value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tui_midpoint (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  logic                req_valid_i,
  input  tui_pkg::mid_req_t   req_i,
  output logic                res_valid_o,
  output tui_pkg::out_item_t  res_o
);

  localparam int unsigned SW  = tui_pkg::SampleWidth;
  localparam int unsigned NW  = SW + 9;
  localparam int unsigned MW  = SW + 4;
  localparam int unsigned UW  = SW + 3;
  localparam int unsigned LoW = UW / 2;
  localparam int unsigned HiW = UW - LoW;
  localparam int unsigned PW  = 2 * UW;

  localparam logic [UW:0]            PowU    = {1'b1, {UW{1'b0}}};
  localparam logic [UW-1:0]          Recip   = UW'(PowU / 5);
  localparam logic signed [MW-1:0]   ClampHi = $signed((MW'(5) << (SW - 1)) - MW'(1));
  localparam logic signed [MW-1:0]   ClampLo = ~ClampHi;

  typedef struct packed {
    tui_pkg::sample_t fast;
    logic             use_fast;
    logic             interpolated;
    logic             final_res;
  } tag_t;

  logic signed [SW:0]    sum_bc, sum_ad, bc_inc;
  logic signed [NW-1:0]  bc_ext, ad_ext, num;
  tag_t                  tag0;

  logic                  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [NW-1:0]         num1_q;
  tag_t                  tag1_q, tag2_q, tag3_q, tag4_q;
  logic [UW-1:0]         u2_q, u3_q, u4_q;
  logic [LoW+UW-1:0]     plo3_q;
  logic [HiW+UW-1:0]     phi3_q;
  logic [SW-1:0]         q4_q;
  tui_pkg::out_item_t    res_q;

  logic signed [MW-1:0]  quo, clamped;
  logic [MW-1:0]         shifted;
  logic [LoW+UW-1:0]     plo;
  logic [HiW+UW-1:0]     phi;
  logic [PW-1:0]         prod;
  logic [UW-1:0]         q_times5, rem;
  logic [SW-1:0]         q_fix;
  tui_pkg::sample_t      acc_value;

  assign sum_bc = {req_i.b[SW-1], req_i.b} + {req_i.c[SW-1], req_i.c};
  assign sum_ad = {req_i.a[SW-1], req_i.a} + {req_i.d[SW-1], req_i.d};
  assign bc_inc = sum_bc + (SW + 1)'(1);
  assign bc_ext = {{(NW - SW - 1){sum_bc[SW]}}, sum_bc};
  assign ad_ext = {{(NW - SW - 1){sum_ad[SW]}}, sum_ad};
  assign num    = (bc_ext <<< 6) + (bc_ext <<< 4) + bc_ext - ad_ext + NW'(80);

  always_comb begin
    tag0.fast         = req_i.pass ? req_i.b : bc_inc[SW:1];
    tag0.use_fast     = req_i.pass || req_i.velocity;
    tag0.interpolated = req_i.interpolated;
    tag0.final_res    = req_i.final_res;
  end

  assign quo     = num1_q[NW-1:5];
  assign clamped = (quo < ClampLo) ? ClampLo : ((quo > ClampHi) ? ClampHi : quo);
  assign shifted = clamped - ClampLo;

  assign plo = u2_q[LoW-1:0] * Recip;
  assign phi = u2_q[UW-1:LoW] * Recip;

  assign prod = {phi3_q, {LoW{1'b0}}} + PW'(plo3_q);

  assign q_times5  = {q4_q, 2'b00} + UW'(q4_q);
  assign rem       = u4_q - q_times5;
  assign q_fix     = q4_q + SW'(rem >= UW'(5));
  assign acc_value = {~q_fix[SW-1], q_fix[SW-2:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= req_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num1_q <= num;
    tag1_q <= tag0;
    u2_q   <= shifted[UW-1:0];
    tag2_q <= tag1_q;
    plo3_q <= plo;
    phi3_q <= phi;
    u3_q   <= u2_q;
    tag3_q <= tag2_q;
    q4_q   <= prod[UW+SW-1:UW];
    u4_q   <= u3_q;
    tag4_q <= tag3_q;
    res_q.value        <= tag4_q.use_fast ? tag4_q.fast : acc_value;
    res_q.interpolated <= tag4_q.interpolated;
    res_q.final_res    <= tag4_q.final_res;
  end

  assign res_valid_o = v5_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tui_back.sv =====
// ----------------------------------------------------------------------------
// tui_back
// Walks the result slots of each queued command, one slot per cycle, and
// issues them to the midpoint pipeline against credits of the output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tui_back #(
  parameter int unsigned OutDepth = 8
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  logic               cmd_empty_i,
  input  tui_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  tui_pkg::sample_t   goal_i,
  input  logic               velocity_i,
  input  logic               out_pop_i,
  output logic               req_valid_o,
  output tui_pkg::mid_req_t  req_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  tui_pkg::slot_e    slot, start_slot, end_slot, slot_q;
  logic              busy_q, issue, req_valid_q;
  logic [CntW-1:0]   reserved_q, reserved_d;
  tui_pkg::mid_req_t req, req_q;

  assign start_slot = cmd_i.has_prev ? tui_pkg::SlotMidBefore : tui_pkg::SlotMidAfter;
  assign end_slot   = cmd_i.last ? tui_pkg::SlotMidGoal : tui_pkg::SlotPrev;
  assign slot       = busy_q ? slot_q : start_slot;
  assign issue      = !cmd_empty_i && (reserved_q < CntW'(OutDepth));
  assign cmd_pop_o  = issue && (slot == end_slot);
  assign reserved_d = reserved_q + CntW'(issue) - CntW'(out_pop_i);

  always_comb begin
    req.a            = cmd_i.p1;
    req.b            = cmd_i.p1;
    req.c            = cmd_i.x;
    req.d            = goal_i;
    req.pass         = 1'b0;
    req.velocity     = velocity_i;
    req.interpolated = 1'b1;
    req.final_res    = 1'b0;
    unique case (slot)
      tui_pkg::SlotMidBefore: begin
        req.a = cmd_i.p3;
        req.b = cmd_i.p2;
        req.c = cmd_i.p1;
        req.d = cmd_i.x;
      end
      tui_pkg::SlotPrev: begin
        req.b            = cmd_i.p1;
        req.pass         = 1'b1;
        req.interpolated = 1'b0;
      end
      tui_pkg::SlotMidAfter: begin
        req.a = cmd_i.p2;
        req.b = cmd_i.p1;
        req.c = cmd_i.x;
        req.d = goal_i;
      end
      tui_pkg::SlotSample: begin
        req.b            = cmd_i.x;
        req.pass         = 1'b1;
        req.interpolated = 1'b0;
      end
      tui_pkg::SlotMidGoal: begin
        req.a         = cmd_i.p1;
        req.b         = cmd_i.x;
        req.c         = goal_i;
        req.d         = goal_i;
        req.final_res = 1'b1;
      end
      default: begin
        req.pass = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= tui_pkg::SlotMidBefore;
      reserved_q  <= '0;
      req_valid_q <= 1'b0;
    end else begin
      reserved_q  <= reserved_d;
      req_valid_q <= issue;
      if (issue) begin
        if (slot == end_slot) begin
          busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
          slot_q <= tui_pkg::slot_e'(slot + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      req_q <= req;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

// ===== hw/rtl/trajectory_upsample_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// trajectory_upsample_interpolator_core
// Twice-dense four-point interpolating upsampler for one joint's trajectory.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle, while the short command queue is not full,
// and each command is expanded by the back sequencer into its results at one
// result per cycle while output queue credits remain, so a sample in
// mid-trajectory yields two results and a sample marked last up to five. The
// sequencer issue slot is the limit; the issue register, the midpoint pipeline
// and the output queue lie between a command reaching the queue head and its
// first result becoming visible. Configuration writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none

module trajectory_upsample_interpolator_core #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned OutDepth = 8
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  logic                                    push,
  output logic                                    full,
  input  tui_pkg::in_item_t                       in_i,
  output logic                                    empty,
  input  logic                                    pop,
  output tui_pkg::out_item_t                      out_o,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tui_pkg::CfgIndexWidth-1:0]       cfg_index_i,
  input  tui_pkg::sample_t                        cfg_data_i
);

  tui_pkg::sample_t   start_q, goal_q;
  logic               velocity_q;
  logic               accept, cmd_push, cmd_full, cmd_empty, cmd_pop;
  tui_pkg::cmd_t      cmd_in, cmd_head;
  logic               req_valid, res_valid, out_full, out_pop;
  tui_pkg::mid_req_t  req;
  tui_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign out_pop   = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      goal_q     <= '0;
      velocity_q <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tui_pkg::cfg_reg_e'(cfg_index_i))
        tui_pkg::CfgStartValue:   start_q    <= cfg_data_i;
        tui_pkg::CfgGoalValue:    goal_q     <= cfg_data_i;
        tui_pkg::CfgVelocityMode: velocity_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  tui_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_i),
    .start_i    (start_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  tui_fifo #(
    .T     (tui_pkg::cmd_t),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  tui_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .goal_i      (goal_q),
    .velocity_i  (velocity_q),
    .out_pop_i   (out_pop),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  tui_midpoint u_midpoint (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tui_fifo #(
    .T     (tui_pkg::out_item_t),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid |-> !out_full)
    else $error("Result arrived at a full output queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("Command pushed into a full command queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.final_res) |-> out_o.interpolated)
    else $error("Final transaction is not a midpoint.");

endmodule

`default_nettype wire
